// ----- rtl/wav_hdr_pkg.sv -----
// Shared types and constants for the RIFF/WAVE header parser.
// Used by wav_hdr_core and wav_header_parser; depends on nothing else.

package wav_hdr_pkg;

   // Parser phases
   typedef enum logic [3:0] {
      PH_RIFF    = 4'd0,
      PH_RSIZE   = 4'd1,
      PH_WAVE    = 4'd2,
      PH_CTAG    = 4'd3,
      PH_CSIZE   = 4'd4,
      PH_FMT     = 4'd5,
      PH_SKIP    = 4'd6,
      PH_PAYLOAD = 4'd7,
      PH_ERROR   = 4'd8
   } phase_type;

   // Status codes on the result word
   localparam logic [1:0] ST_HEADER  = 2'd0;
   localparam logic [1:0] ST_PAYLOAD = 2'd1;
   localparam logic [1:0] ST_ERROR   = 2'd2;

   // Error kinds
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_RIFF      = 3'd1;
   localparam logic [2:0] ERR_WAVE      = 3'd2;
   localparam logic [2:0] ERR_FMT_SIZE  = 3'd3;
   localparam logic [2:0] ERR_NOT_PCM   = 3'd4;
   localparam logic [2:0] ERR_CHANNELS  = 3'd5;
   localparam logic [2:0] ERR_TRUNCATED = 3'd6;
   localparam logic [2:0] ERR_DATA_EARLY = 3'd7;

   // Four-character tags, first byte in the low bits
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // Field lengths in bytes
   localparam logic [31:0] FIELD_BYTES = 32'd4;
   localparam logic [31:0] FMT_BYTES   = 32'd16;
   localparam logic [31:0] FMT_RATE_END = 32'd8;
   localparam logic [31:0] FMT_BITS_START = 32'd14;

   localparam logic [15:0] FORMAT_PCM = 16'd1;

   // One result word
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  payload_byte;
      logic [1:0]  channel_count;
      logic [31:0] sample_rate;
      logic [15:0] sample_bits;
      logic [31:0] data_bytes;
      logic [2:0]  error_kind;
   } result_type;

endpackage

// ----- rtl/wav_hdr_core.sv -----
// Byte-wise header parse state and its per-byte update.
// Depends on wav_hdr_pkg; instantiated by wav_header_parser.

module wav_hdr_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               file_byte,
   input  logic                     is_last,
   output wav_hdr_pkg::result_type  result
);

   wav_hdr_pkg::phase_type phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] tag_ff, tag_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [1:0]  chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] pend_ff, pend_in;
   logic [31:0] size_ff, size_in;
   logic [2:0]  err_ff, err_in;

   logic [31:0] cnt_inc;
   logic [31:0] cnt_dec;
   logic [31:0] tag_shift;
   logic [31:0] asm_shift;
   logic [15:0] pend_shift;
   logic        payload;

   assign cnt_inc    = cnt_ff + 32'd1;
   assign cnt_dec    = cnt_ff - 32'd1;
   assign tag_shift  = {file_byte, tag_ff[31:8]};
   assign asm_shift  = {file_byte, asm_ff[31:8]};
   assign pend_shift = {file_byte, pend_ff[15:8]};

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wav_hdr_pkg::PH_RIFF;
         cnt_ff      <= '0;
         asm_ff      <= '0;
         tag_ff      <= '0;
         fmt_seen_ff <= 1'b0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         pend_ff     <= '0;
         size_ff     <= '0;
         err_ff      <= wav_hdr_pkg::ERR_NONE;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         asm_ff      <= asm_in;
         tag_ff      <= tag_in;
         fmt_seen_ff <= fmt_seen_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         pend_ff     <= pend_in;
         size_ff     <= size_in;
         err_ff      <= err_in;
      end
   end

   // Next state for one byte
   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      asm_in      = asm_ff;
      tag_in      = tag_ff;
      fmt_seen_in = fmt_seen_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      pend_in     = pend_ff;
      size_in     = size_ff;
      err_in      = err_ff;
      payload     = 1'b0;

      unique case (phase_ff)
         wav_hdr_pkg::PH_RIFF, wav_hdr_pkg::PH_WAVE: begin
            tag_in = tag_shift;
            cnt_in = cnt_inc;
            if (cnt_inc == wav_hdr_pkg::FIELD_BYTES) begin
               cnt_in = '0;
               if (phase_ff == wav_hdr_pkg::PH_RIFF) begin
                  if (tag_shift != wav_hdr_pkg::TAG_RIFF) begin
                     err_in   = wav_hdr_pkg::ERR_RIFF;
                     phase_in = wav_hdr_pkg::PH_ERROR;
                  end else begin
                     phase_in = wav_hdr_pkg::PH_RSIZE;
                  end
               end else begin
                  if (tag_shift != wav_hdr_pkg::TAG_WAVE) begin
                     err_in   = wav_hdr_pkg::ERR_WAVE;
                     phase_in = wav_hdr_pkg::PH_ERROR;
                  end else begin
                     phase_in = wav_hdr_pkg::PH_CTAG;
                  end
               end
            end
         end
         wav_hdr_pkg::PH_RSIZE: begin
            cnt_in = cnt_inc;
            if (cnt_inc == wav_hdr_pkg::FIELD_BYTES) begin
               cnt_in   = '0;
               phase_in = wav_hdr_pkg::PH_WAVE;
            end
         end
         wav_hdr_pkg::PH_CTAG: begin
            tag_in = tag_shift;
            cnt_in = cnt_inc;
            if (cnt_inc == wav_hdr_pkg::FIELD_BYTES) begin
               cnt_in   = '0;
               phase_in = wav_hdr_pkg::PH_CSIZE;
            end
         end
         wav_hdr_pkg::PH_CSIZE: begin
            asm_in = asm_shift;
            cnt_in = cnt_inc;
            if (cnt_inc == wav_hdr_pkg::FIELD_BYTES) begin
               cnt_in = '0;
               priority if (tag_ff == wav_hdr_pkg::TAG_FMT) begin
                  if (asm_shift != wav_hdr_pkg::FMT_BYTES) begin
                     err_in   = wav_hdr_pkg::ERR_FMT_SIZE;
                     phase_in = wav_hdr_pkg::PH_ERROR;
                  end else begin
                     phase_in = wav_hdr_pkg::PH_FMT;
                  end
               end else if (tag_ff == wav_hdr_pkg::TAG_DATA) begin
                  if (!fmt_seen_ff) begin
                     err_in   = wav_hdr_pkg::ERR_DATA_EARLY;
                     phase_in = wav_hdr_pkg::PH_ERROR;
                  end else begin
                     size_in  = asm_shift;
                     phase_in = wav_hdr_pkg::PH_PAYLOAD;
                  end
               end else if (asm_shift == '0) begin
                  // empty chunk: next byte opens a new tag
                  phase_in = wav_hdr_pkg::PH_CTAG;
               end else begin
                  cnt_in   = asm_shift;
                  phase_in = wav_hdr_pkg::PH_SKIP;
               end
            end
         end
         wav_hdr_pkg::PH_SKIP: begin
            cnt_in = cnt_dec;
            if (cnt_dec == '0) begin
               phase_in = wav_hdr_pkg::PH_CTAG;
            end
         end
         wav_hdr_pkg::PH_FMT: begin
            // format tag and channels, then rate, then bits per sample
            priority if (cnt_ff < wav_hdr_pkg::FIELD_BYTES) begin
               tag_in = tag_shift;
            end else if (cnt_ff < wav_hdr_pkg::FMT_RATE_END) begin
               asm_in = asm_shift;
            end else if (cnt_ff >= wav_hdr_pkg::FMT_BITS_START) begin
               pend_in = pend_shift;
            end else begin
               pend_in = pend_ff;
            end
            cnt_in = cnt_inc;
            if (cnt_inc == wav_hdr_pkg::FMT_BYTES) begin
               cnt_in = '0;
               priority if (tag_ff[15:0] != wav_hdr_pkg::FORMAT_PCM) begin
                  err_in   = wav_hdr_pkg::ERR_NOT_PCM;
                  phase_in = wav_hdr_pkg::PH_ERROR;
               end else if (tag_ff[31:16] != 16'd1 && tag_ff[31:16] != 16'd2) begin
                  err_in   = wav_hdr_pkg::ERR_CHANNELS;
                  phase_in = wav_hdr_pkg::PH_ERROR;
               end else begin
                  chan_in     = tag_ff[17:16];
                  rate_in     = asm_ff;
                  bits_in     = pend_in;
                  fmt_seen_in = 1'b1;
                  phase_in    = wav_hdr_pkg::PH_CTAG;
               end
            end
         end
         wav_hdr_pkg::PH_PAYLOAD: begin
            payload = 1'b1;
         end
         default: begin
            // error phase holds until reset
         end
      endcase

      // end of file inside the header
      if (is_last && phase_in != wav_hdr_pkg::PH_PAYLOAD
            && phase_in != wav_hdr_pkg::PH_ERROR) begin
         err_in   = wav_hdr_pkg::ERR_TRUNCATED;
         phase_in = wav_hdr_pkg::PH_ERROR;
      end
   end

   // Result word from the updated state
   always_comb begin
      if (phase_in == wav_hdr_pkg::PH_ERROR) begin
         result.status = wav_hdr_pkg::ST_ERROR;
      end else if (payload) begin
         result.status = wav_hdr_pkg::ST_PAYLOAD;
      end else begin
         result.status = wav_hdr_pkg::ST_HEADER;
      end
      result.payload_byte  = payload ? file_byte : 8'd0;
      result.channel_count = chan_in;
      result.sample_rate   = rate_in;
      result.sample_bits   = bits_in;
      result.data_bytes    = size_in;
      result.error_kind    = err_in;
   end

endmodule

// ----- rtl/wav_header_parser.sv -----
// Top level of the RIFF/WAVE PCM header parser: stream handshake and result register.
// Depends on wav_hdr_pkg and wav_hdr_core.
//
// Usage:
//   The req_ channel carries the file one byte per word, req_tlast marking the
//   final byte. Every accepted word yields exactly one rsp_ word holding the
//   status (rsp_tuser), the payload byte and the header values kept so far.
//   Once the 'data' chunk header is through, each following byte comes out
//   with status payload; any header fault gives status error, sticky until reset.
// Result: the result for a byte is registered and valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while rsp_tready stays high; the per-byte update of the parse state is a
//   single register step, so the only limit is the output register.
// Reset: synchronous, active high; returns to expecting the RIFF tag, clears all
//   kept values and the error, and empties the result register.
// Stall: while rsp_tready is low and a result waits, req_tready drops and the
//   result holds; with rsp_tready high, a new byte is taken in the same cycle
//   the waiting result leaves.

module wav_header_parser (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] file_byte
   input  logic        req_tlast,   // is_last
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [7:0] payload_byte, [9:8] channel_count,
                                    // [41:10] sample_rate, [57:42] sample_bits,
                                    // [89:58] data_bytes, [92:90] error_kind, rest 0
   output logic [1:0]  rsp_tuser    // status
);

   logic                    req_accept;
   logic                    rsp_valid_ff;
   wav_hdr_pkg::result_type rsp_data_ff;
   wav_hdr_pkg::result_type step_result;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   wav_hdr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_accept),
      .file_byte (req_tdata),
      .is_last   (req_tlast),
      .result    (step_result)
   );

   // Result register valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.error_kind,
                        rsp_data_ff.data_bytes,
                        rsp_data_ff.sample_bits,
                        rsp_data_ff.sample_rate,
                        rsp_data_ff.channel_count,
                        rsp_data_ff.payload_byte};

   // Error status always carries a cause, and payload never does
   a_error_has_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == wav_hdr_pkg::ST_ERROR
      |-> rsp_data_ff.error_kind != wav_hdr_pkg::ERR_NONE)
      else $error("error status without error kind");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == wav_hdr_pkg::ST_PAYLOAD
      |-> rsp_data_ff.error_kind == wav_hdr_pkg::ERR_NONE
          && rsp_data_ff.channel_count != 2'd0)
      else $error("payload while in error or before fmt");

   // Errors are sticky across accepted bytes
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == wav_hdr_pkg::ST_ERROR && req_accept
      |=> rsp_data_ff.status == wav_hdr_pkg::ST_ERROR)
      else $error("error status cleared without reset");

   // Header and error status never carry a payload byte
   a_header_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != wav_hdr_pkg::ST_PAYLOAD
      |-> rsp_data_ff.payload_byte == 8'd0)
      else $error("payload byte outside payload status");

endmodule
